/* design/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared constants, types and tables of the text terminal character engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;

  localparam logic [7:0] SPACE = 8'h20;

  // commands
  localparam logic [1:0] CMD_PUT     = 2'd0;
  localparam logic [1:0] CMD_RD_CELL = 2'd1;
  localparam logic [1:0] CMD_RD_BIT  = 2'd2;

  // background modes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_BG  = 2'd1;
  localparam logic [1:0] MODE_FG  = 2'd2;

  // escape phases
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  // control codes
  localparam logic [7:0] CC_INS_LINE = 8'h01;
  localparam logic [7:0] CC_DEL_LINE = 8'h02;
  localparam logic [7:0] CC_LEFT_A   = 8'h05;
  localparam logic [7:0] CC_ESCAPE   = 8'h06;
  localparam logic [7:0] CC_LEFT_B   = 8'h08;
  localparam logic [7:0] CC_TAB      = 8'h09;
  localparam logic [7:0] CC_LF       = 8'h0A;
  localparam logic [7:0] CC_CLEAR    = 8'h0C;
  localparam logic [7:0] CC_CR       = 8'h0D;
  localparam logic [7:0] CC_BG_MODE  = 8'h13;
  localparam logic [7:0] CC_FG_MODE  = 8'h14;
  localparam logic [7:0] CC_FG_BLANK = 8'h15;
  localparam logic [7:0] CC_RIGHT    = 8'h18;
  localparam logic [7:0] CC_UP       = 8'h1A;
  localparam logic [7:0] CC_HOME     = 8'h1D;
  localparam logic [7:0] CC_ERASE_EOL = 8'h1E;
  localparam logic [7:0] CC_ERASE_EOS = 8'h1F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWRD,
    ST_SWWR,
    ST_RESP,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    SW_CLEAR,
    SW_SCROLL,
    SW_INSERT,
    SW_DELETE,
    SW_BGCLR,
    SW_FGBLANK,
    SW_EOL,
    SW_EOS
  } sweep_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sw_rd;
    logic sw_wr;
    logic resp;
  } ctl_t;

  typedef struct packed {
    logic sweep_go;
    logic sweep_last;
  } sts_t;

  typedef logic [COL_W-1:0] col_tab_t [256];
  typedef logic [ROW_W-1:0] row_tab_t [256];

  function automatic col_tab_t build_col_tab();
    col_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = COL_W'(i % COLUMNS);
    end
    return t;
  endfunction

  function automatic row_tab_t build_row_tab();
    row_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ROW_W'(i % ROWS);
    end
    return t;
  endfunction

  localparam col_tab_t COL_MOD = build_col_tab();
  localparam row_tab_t ROW_MOD = build_row_tab();

endpackage

/* design/tte_ram.sv */
// ----------------------------------------------------------------------------
// tte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/tte_ctrl.sv */
// ----------------------------------------------------------------------------
// tte_ctrl
// Sequencer: request intake, decode step, cell sweeps, result strobe.
// ----------------------------------------------------------------------------
module tte_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output tte_pkg::ctl_t ctl_o,
  input  tte_pkg::sts_t sts_i
);
  import tte_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        init_q, init_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWRD;   // clearing pass after reset
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = sts_i.sweep_go ? ST_SWRD : ST_RESP;
      ST_SWRD: state_d = ST_SWWR;
      ST_SWWR: begin
        if (!sts_i.sweep_last) begin
          state_d = ST_SWRD;
        end else if (init_q) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        ctl_o.capture = start_i;
      end
      ST_EXEC: ctl_o.exec  = 1'b1;
      ST_SWRD: ctl_o.sw_rd = 1'b1;
      ST_SWWR: ctl_o.sw_wr = 1'b1;
      ST_RESP: ctl_o.resp  = 1'b1;
      ST_OUT:  done_o      = 1'b1;
      default: busy_o      = 1'b1;
    endcase
  end

endmodule

/* design/tte_datapath.sv */
// ----------------------------------------------------------------------------
// tte_datapath
// Cursor and mode registers, escape decode, screen and bitmap RAMs, sweeps.
// ----------------------------------------------------------------------------
module tte_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tte_pkg::ctl_t              ctl_i,
  output tte_pkg::sts_t              sts_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_data_i,
  input  logic [1:0]                 command_i,
  input  logic [7:0]                 code_byte_i,
  input  logic [10:0]                cell_address_i,
  output logic [7:0]                 read_data_o,
  output logic [tte_pkg::COL_W-1:0]  cursor_column_o,
  output logic [tte_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [1:0]                 background_mode_o,
  output logic [1:0]                 escape_pending_o
);
  import tte_pkg::*;

  // architectural state
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       mode_q, mode_d;
  logic [1:0]       esc_q, esc_d;
  logic [7:0]       first_q, first_d;
  logic             order_q;

  // captured request
  logic [1:0]  cmd_q;
  logic [7:0]  code_q;
  logic [10:0] addr_q;

  // sweep state
  sweep_e           op_q, op_d;
  logic [ADDR_W-1:0] idx_q, idx_d, end_q, end_d, lim_q, lim_d;
  logic             down_q, down_d;
  logic             sw_go;

  // decode helpers
  logic [ADDR_W-1:0] rbase, pos;
  logic [COL_W:0]    adv_sum;
  logic              adv_wrap;
  logic [7:0]        coord, col_src, row_src;
  logic              char_we, char_bit_we;

  // sweep helpers
  logic              copy_now, copy_op;
  logic [ADDR_W-1:0] src;
  logic              sw_scr_we, sw_bit_we;

  // RAM ports
  logic              scr_we, bit_we;
  logic [ADDR_W-1:0] waddr, scr_raddr, bit_raddr, rd_addr;
  logic [7:0]        scr_wdata, scr_rdata;
  logic              bit_wdata, bit_rdata;
  logic              in_range;

  assign rbase = ADDR_W'(row_q * COLUMNS);
  assign pos   = rbase + ADDR_W'(col_q);

  assign in_range = ({1'b0, addr_q} < (ADDR_W + 1)'(CELLS));
  assign rd_addr  = in_range ? ADDR_W'(addr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= command_i;
      code_q <= code_byte_i;
      addr_q <= cell_address_i;
    end
  end

  // decode one request
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    mode_d      = mode_q;
    esc_d       = esc_q;
    first_d     = first_q;
    sw_go       = 1'b0;
    op_d        = op_q;
    idx_d       = idx_q;
    end_d       = end_q;
    lim_d       = lim_q;
    down_d      = down_q;
    char_we     = 1'b0;
    char_bit_we = 1'b0;

    adv_sum  = {1'b0, col_q} + ((code_q == CC_TAB) ? (COL_W + 1)'(4) : (COL_W + 1)'(1));
    adv_wrap = (adv_sum >= (COL_W + 1)'(COLUMNS));
    coord    = 8'((code_q & 8'h7F) - SPACE);
    col_src  = order_q ? coord : first_q;
    row_src  = order_q ? first_q : coord;

    if (cmd_q == CMD_PUT) begin
      if (esc_q != ESC_NONE) begin
        if (esc_q == ESC_FIRST) begin
          first_d = coord;
          esc_d   = ESC_SECOND;
        end else begin
          col_d = COL_MOD[col_src];
          row_d = ROW_MOD[row_src];
          esc_d = ESC_NONE;
        end
      end else if (code_q < SPACE) begin
        unique case (code_q)
          CC_INS_LINE: begin
            sw_go  = 1'b1;
            op_d   = SW_INSERT;
            idx_d  = ADDR_W'(CELLS - 1);
            end_d  = rbase;
            lim_d  = rbase + ADDR_W'(COLUMNS);
            down_d = 1'b1;
          end
          CC_DEL_LINE: begin
            sw_go  = 1'b1;
            op_d   = SW_DELETE;
            idx_d  = rbase;
            end_d  = ADDR_W'(CELLS - 1);
            lim_d  = ADDR_W'((ROWS - 1) * COLUMNS);
            down_d = 1'b0;
          end
          CC_LEFT_A, CC_LEFT_B: begin
            if (col_q != '0) begin
              col_d = col_q - COL_W'(1);
            end else begin
              col_d = COL_W'(COLUMNS - 1);
              row_d = (row_q != '0) ? row_q - ROW_W'(1) : ROW_W'(ROWS - 1);
            end
          end
          CC_ESCAPE: esc_d = ESC_FIRST;
          CC_LF: begin
            if (row_q < ROW_W'(ROWS - 1)) begin
              row_d = row_q + ROW_W'(1);
            end else begin
              sw_go = 1'b1;
              op_d  = SW_SCROLL;
            end
          end
          CC_CLEAR: begin
            col_d = '0;
            row_d = '0;
            sw_go = 1'b1;
            op_d  = SW_CLEAR;
          end
          CC_CR: col_d = '0;
          CC_BG_MODE: begin
            mode_d = MODE_BG;
            sw_go  = 1'b1;
            op_d   = SW_BGCLR;
          end
          CC_FG_MODE: mode_d = MODE_FG;
          CC_FG_BLANK: begin
            sw_go = 1'b1;
            op_d  = SW_FGBLANK;
          end
          CC_TAB, CC_RIGHT: begin
            col_d = adv_wrap ? COL_W'(adv_sum - (COL_W + 1)'(COLUMNS)) : COL_W'(adv_sum);
            if (adv_wrap) begin
              if (row_q < ROW_W'(ROWS - 1)) begin
                row_d = row_q + ROW_W'(1);
              end else begin
                sw_go = 1'b1;
                op_d  = SW_SCROLL;
              end
            end
          end
          CC_UP: row_d = (row_q != '0) ? row_q - ROW_W'(1) : ROW_W'(ROWS - 1);
          CC_HOME: begin
            col_d = '0;
            row_d = '0;
          end
          CC_ERASE_EOL: begin
            sw_go  = 1'b1;
            op_d   = SW_EOL;
            idx_d  = pos;
            end_d  = rbase + ADDR_W'(COLUMNS - 1);
            down_d = 1'b0;
          end
          CC_ERASE_EOS: begin
            sw_go  = 1'b1;
            op_d   = SW_EOS;
            idx_d  = pos;
            end_d  = ADDR_W'(CELLS - 1);
            down_d = 1'b0;
          end
          default: ;
        endcase
      end else begin
        // printable: store, mark (in background mode), advance
        char_we     = 1'b1;
        char_bit_we = (mode_q == MODE_BG);
        col_d = adv_wrap ? COL_W'(adv_sum - (COL_W + 1)'(COLUMNS)) : COL_W'(adv_sum);
        if (adv_wrap) begin
          if (row_q < ROW_W'(ROWS - 1)) begin
            row_d = row_q + ROW_W'(1);
          end else begin
            sw_go = 1'b1;
            op_d  = SW_SCROLL;
          end
        end
      end
    end

    // whole-screen sweeps run ascending over every cell
    if (sw_go && (op_d == SW_SCROLL || op_d == SW_CLEAR ||
                  op_d == SW_BGCLR || op_d == SW_FGBLANK)) begin
      idx_d  = '0;
      end_d  = ADDR_W'(CELLS - 1);
      lim_d  = ADDR_W'((ROWS - 1) * COLUMNS);
      down_d = 1'b0;
    end
  end

  assign sts_o.sweep_go   = sw_go;
  assign sts_o.sweep_last = (idx_q == end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      mode_q  <= MODE_OFF;
      esc_q   <= ESC_NONE;
      first_q <= '0;
      op_q    <= SW_CLEAR;
      idx_q   <= '0;
      end_q   <= ADDR_W'(CELLS - 1);
      lim_q   <= '0;
      down_q  <= 1'b0;
    end else if (ctl_i.exec) begin
      col_q   <= col_d;
      row_q   <= row_d;
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      first_q <= first_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      lim_q   <= lim_d;
      down_q  <= down_d;
    end else if (ctl_i.sw_wr) begin
      idx_q <= down_q ? idx_q - ADDR_W'(1) : idx_q + ADDR_W'(1);
    end
  end

  // per-cell sweep step
  assign copy_op  = (op_q == SW_SCROLL) || (op_q == SW_DELETE) || (op_q == SW_INSERT);
  assign copy_now = (op_q == SW_INSERT) ? (idx_q >= lim_q)
                  : (copy_op && (idx_q < lim_q));
  assign src      = !copy_now ? idx_q
                  : (down_q ? idx_q - ADDR_W'(COLUMNS) : idx_q + ADDR_W'(COLUMNS));

  assign sw_scr_we = (op_q != SW_BGCLR) && ((op_q != SW_FGBLANK) || !bit_rdata);
  assign sw_bit_we = (op_q == SW_CLEAR) || (op_q == SW_BGCLR) ||
                     (copy_op && (mode_q != MODE_OFF));

  assign scr_we    = (ctl_i.exec && char_we) || (ctl_i.sw_wr && sw_scr_we);
  assign bit_we    = (ctl_i.exec && char_bit_we) || (ctl_i.sw_wr && sw_bit_we);
  assign waddr     = ctl_i.exec ? pos : idx_q;
  assign scr_wdata = ctl_i.exec ? code_q : (copy_now ? scr_rdata : SPACE);
  assign bit_wdata = ctl_i.exec ? 1'b1 : (copy_now ? bit_rdata : 1'b0);
  assign scr_raddr = ctl_i.sw_rd ? src : rd_addr;
  assign bit_raddr = ctl_i.sw_rd ? src : rd_addr;

  tte_ram #(.WIDTH(8), .DEPTH(CELLS)) u_screen (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  tte_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bit_we),
    .waddr_i (waddr),
    .wdata_i (bit_wdata),
    .raddr_i (bit_raddr),
    .rdata_o (bit_rdata)
  );

  // result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.resp) begin
      if (in_range && cmd_q == CMD_RD_CELL) begin
        read_data_o <= scr_rdata;
      end else if (in_range && cmd_q == CMD_RD_BIT) begin
        read_data_o <= {7'd0, bit_rdata};
      end else begin
        read_data_o <= 8'd0;
      end
      cursor_column_o   <= col_q;
      cursor_row_o      <= row_q;
      background_mode_o <= mode_q;
      escape_pending_o  <= esc_q;
    end
  end

endmodule

/* design/text_terminal_character_engine.sv */
// ----------------------------------------------------------------------------
// text_terminal_character_engine
// Character screen terminal engine: put bytes, read cells and bitmap bits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive command_i, code_byte_i and cell_address_i and raise start_i; the
//   request is taken at an edge where start_i is high and busy_o is low.
//   One result per request is loaded into the result ports, with done_o
//   high for exactly one cycle; the receiver cannot hold it off.
//   A read or a simple put (cursor move, printable byte without a
//   bottom-row wrap, escape byte) goes through the decode and response
//   states to done_o. Scroll, insert/delete line, clear, erase and the
//   background-mode passes read and then write each affected cell of the
//   screen and bitmap RAMs, as each RAM has a single read port. One
//   request is in flight at a time; busy_o stays high until done_o.
//   Reset: the cursor, mode, escape, sweep and order registers clear, then
//   a clearing pass fills the screen with spaces and the bitmap with zeros
//   with busy_o high. The user must write address_order through cfg_we_i /
//   cfg_data_i only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_terminal_character_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  output logic                      done_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_data_i,
  input  logic [1:0]                command_i,
  input  logic [7:0]                code_byte_i,
  input  logic [10:0]               cell_address_i,
  output logic [7:0]                read_data_o,
  output logic [tte_pkg::COL_W-1:0] cursor_column_o,
  output logic [tte_pkg::ROW_W-1:0] cursor_row_o,
  output logic [1:0]                background_mode_o,
  output logic [1:0]                escape_pending_o
);
  import tte_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequence each request
  tte_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctl_o   (ctl),
    .sts_i   (sts)
  );

  // hold screen, bitmap, cursor and modes
  tte_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .code_byte_i       (code_byte_i),
    .cell_address_i    (cell_address_i),
    .read_data_o       (read_data_o),
    .cursor_column_o   (cursor_column_o),
    .cursor_row_o      (cursor_row_o),
    .background_mode_o (background_mode_o),
    .escape_pending_o  (escape_pending_o)
  );

endmodule

/* design/tte_checker.sv */
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
module tte_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [tte_pkg::COL_W-1:0] cursor_column_o,
  input logic [tte_pkg::ROW_W-1:0] cursor_row_o,
  input logic [1:0]                escape_pending_o
);
  import tte_pkg::*;

  // a result only ends an accepted request
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accept not followed by busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((cursor_row_o < ROW_W'(ROWS)) && (cursor_column_o < COL_W'(COLUMNS))
                && (escape_pending_o != 2'd3)))
    else $error("cursor or escape phase out of range");

endmodule

bind text_terminal_character_engine tte_checker u_tte_checker (.*);
